// File: rtl/core/blstk_pkg.sv
// Shared types and constants for the bounded LIFO stack block.
// No dependencies; imported by every module in rtl/core.
package blstk_pkg;

   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_DISPLAY = 2'd2,
      CMD_PAL     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OVER  = 2'd1,
      STAT_UNDER = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WAIT,
      ST_POP,
      ST_DISP,
      ST_PAL_A,
      ST_PAL_B,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [WORD_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [WORD_W-1:0]  data;
      logic                      is_palindrome;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic                      we;
      logic [ADDR_W-1:0]         waddr;
      logic signed [WORD_W-1:0]  wdata;
      logic [ADDR_W-1:0]         raddr;
   } mem_req_type;

endpackage

// File: rtl/core/blstk_mem.sv
// Stack word storage: one write port, one read port with registered data.
// Depends on blstk_pkg.
module blstk_mem (
   input  logic                                clock,
   input  blstk_pkg::mem_req_type              mem_req,
   output logic signed [blstk_pkg::WORD_W-1:0] mem_rdata
);
   import blstk_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: rtl/core/blstk_ctrl.sv
// Command sequencer: fill count, walk pointers and the shared word comparator.
// Depends on blstk_pkg; drives the blstk_mem ports.
module blstk_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  blstk_pkg::req_type                  req_data,
   output logic                                res_valid,
   input  logic                                res_ready,
   output blstk_pkg::rsp_type                  res_data,
   output blstk_pkg::mem_req_type              mem_req,
   input  logic signed [blstk_pkg::WORD_W-1:0] mem_rdata
);
   import blstk_pkg::*;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [ADDR_W-1:0]        lo_ff, lo_in;
   logic [ADDR_W-1:0]        hi_ff, hi_in;
   logic                     phase_ff, phase_in;
   logic signed [WORD_W-1:0] word_a_ff, word_a_in;
   rsp_type                  res_ff, res_in;

   logic [CNT_W-1:0]         cnt_dec;
   logic [ADDR_W:0]          gap;
   logic                     last_pair;
   logic                     word_match;
   logic                     empty;
   logic                     full;

   assign cnt_dec    = cnt_ff - CNT_W'(1);
   assign gap        = {1'b0, hi_ff} - {1'b0, lo_ff};
   assign last_pair  = (gap <= (ADDR_W + 1)'(2));
   assign word_match = (mem_rdata == word_a_ff);
   assign empty      = (cnt_ff == '0);
   assign full       = (cnt_ff == CNT_W'(DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_PUSH:    state_in = ST_EMIT;
                  CMD_POP:     state_in = empty ? ST_EMIT : ST_WAIT;
                  CMD_DISPLAY: state_in = empty ? ST_EMIT : ST_WAIT;
                  CMD_PAL:     state_in = (cnt_ff < CNT_W'(2)) ? ST_EMIT : ST_WAIT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_WAIT: begin
            case (cmd_ff)
               CMD_POP:     state_in = ST_POP;
               CMD_DISPLAY: state_in = ST_DISP;
               CMD_PAL:     state_in = phase_ff ? ST_PAL_B : ST_PAL_A;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_POP: begin
            if (res_ready) state_in = ST_IDLE;
         end
         ST_DISP: begin
            if (res_ready) state_in = (addr_ff == '0) ? ST_IDLE : ST_WAIT;
         end
         ST_PAL_A: state_in = ST_WAIT;
         ST_PAL_B: state_in = (!word_match || last_pair) ? ST_EMIT : ST_WAIT;
         ST_EMIT: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      phase_in      = phase_ff;
      word_a_in     = word_a_ff;
      res_in        = res_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = cnt_ff[ADDR_W-1:0];
      mem_req.wdata = req_data.push_value;
      mem_req.raddr = addr_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      res_data      = res_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               phase_in = 1'b0;
               res_in   = '{status: STAT_OK, data: '0, is_palindrome: 1'b0, last: 1'b1};
               case (req_data.cmd)
                  CMD_PUSH: begin
                     if (full) begin
                        res_in.status = STAT_OVER;
                     end else begin
                        mem_req.we = 1'b1;
                        cnt_in     = cnt_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP: begin
                     if (empty) begin
                        res_in.status = STAT_UNDER;
                     end else begin
                        cnt_in  = cnt_dec;
                        addr_in = cnt_dec[ADDR_W-1:0];
                     end
                  end
                  CMD_DISPLAY: begin
                     if (empty) res_in.status = STAT_UNDER;
                     else addr_in = cnt_dec[ADDR_W-1:0];
                  end
                  CMD_PAL: begin
                     if (empty) begin
                        res_in.status = STAT_UNDER;
                     end else if (cnt_ff == CNT_W'(1)) begin
                        res_in.is_palindrome = 1'b1;
                     end else begin
                        lo_in   = '0;
                        hi_in   = cnt_dec[ADDR_W-1:0];
                        addr_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            res_valid = 1'b1;
            res_data  = '{status: STAT_OK, data: mem_rdata, is_palindrome: 1'b0,
                          last: 1'b1};
         end
         ST_DISP: begin
            res_valid = 1'b1;
            res_data  = '{status: STAT_OK, data: mem_rdata, is_palindrome: 1'b0,
                          last: (addr_ff == '0)};
            if (res_ready && addr_ff != '0) addr_in = addr_ff - ADDR_W'(1);
         end
         ST_PAL_A: begin
            word_a_in = mem_rdata;
            addr_in   = hi_ff;
            phase_in  = 1'b1;
         end
         ST_PAL_B: begin
            res_in = '{status: STAT_OK, data: '0, is_palindrome: 1'b0, last: 1'b1};
            if (word_match) begin
               if (last_pair) begin
                  res_in.is_palindrome = 1'b1;
               end else begin
                  lo_in    = lo_ff + ADDR_W'(1);
                  hi_in    = hi_ff - ADDR_W'(1);
                  addr_in  = lo_ff + ADDR_W'(1);
                  phase_in = 1'b0;
               end
            end
         end
         ST_EMIT: res_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      word_a_ff <= word_a_in;
      res_ff    <= res_in;
   end

endmodule

// File: rtl/core/bounded_lifo_stack_with_palindrome.sv
// Top level of the bounded LIFO stack: sequencer, word storage, result register.
// Depends on blstk_pkg, blstk_mem and blstk_ctrl.
//
// Usage:
//   req_* carries {cmd, push_value}; rsp_* carries {status, data, is_palindrome,
//   last}. Both are valid/ready channels; a transfer happens when valid and
//   ready are high at a rising clock edge.
//   Push, pop, and any command on an empty stack give one result with last set.
//   Display gives one result per stored word, top first, last on the bottom word.
//   Palindrome gives one verdict result.
//   Every storage read goes through the single read port, which has registered data:
//     push / overflow / underflow: result passes through the emit state and the output register
//     pop: a wait state for the read, then the pop state offers the word
//     display: wait and display states alternate, one stored word each
//     palindrome: wait, A and B states read and compare word pairs, outermost first, until a mismatch or the middle
//   Only one item is in work at a time; req_ready is high while the sequencer is
//   idle. A finished result sits in the output register, so the next item can be
//   taken while the receiver stalls; the sequencer then holds its next result.
//   Reset (synchronous) empties the stack and drops any pending result.
module bounded_lifo_stack_with_palindrome (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  blstk_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output blstk_pkg::rsp_type rsp_data
);
   import blstk_pkg::*;

   mem_req_type              mem_req;
   logic signed [WORD_W-1:0] mem_rdata;
   logic                     res_valid;
   logic                     res_ready;
   rsp_type                  res_data;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   blstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   blstk_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   // output register takes a new result whenever it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer never offers a result while it is idle
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !res_valid)
      else $error("result offered while sequencer idle");

   // a result blocked by a full output register is held unchanged
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res_data))
      else $error("blocked result dropped or changed");

   // a drained output register with nothing behind it goes empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !res_valid |=> !rsp_valid_ff)
      else $error("output register did not drain");

endmodule

// File: verif/blstk_checker.sv
// Scoreboard for the bounded LIFO stack: watches both channels, models the stack,
// and compares every response transfer against the predicted queue.
// Depends on blstk_pkg.
`timescale 1ns / 100ps

module blstk_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  blstk_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  blstk_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 outstanding
);
   import blstk_pkg::*;

   logic signed [WORD_W-1:0] words [DEPTH];
   int                       fill = 0;
   int                       errors = 0;
   rsp_type                  expected_q [$];

   assign fail_count = errors;

   function automatic rsp_type mk_result(status_type st, logic signed [WORD_W-1:0] d,
                                         logic pal, logic fin);
      rsp_type res;
      res.status        = st;
      res.data          = d;
      res.is_palindrome = pal;
      res.last          = fin;
      return res;
   endfunction

   function automatic void predict_stack_op(req_type item);
      logic match;
      match = 1'b1;
      case (item.cmd)
         CMD_PUSH: begin
            if (fill >= DEPTH) begin
               expected_q.push_back(mk_result(STAT_OVER, '0, 1'b0, 1'b1));
            end else begin
               words[fill] = item.push_value;
               fill++;
               expected_q.push_back(mk_result(STAT_OK, '0, 1'b0, 1'b1));
            end
         end
         CMD_POP: begin
            if (fill == 0) begin
               expected_q.push_back(mk_result(STAT_UNDER, '0, 1'b0, 1'b1));
            end else begin
               fill--;
               expected_q.push_back(mk_result(STAT_OK, words[fill], 1'b0, 1'b1));
            end
         end
         CMD_DISPLAY: begin
            if (fill == 0) begin
               expected_q.push_back(mk_result(STAT_UNDER, '0, 1'b0, 1'b1));
            end else begin
               // top of stack first, last flag on the bottom word
               for (int i = fill - 1; i >= 0; i--)
                  expected_q.push_back(mk_result(STAT_OK, words[i], 1'b0, i == 0));
            end
         end
         default: begin
            if (fill == 0) begin
               expected_q.push_back(mk_result(STAT_UNDER, '0, 1'b0, 1'b1));
            end else begin
               for (int i = 0; i < fill / 2; i++)
                  if (words[i] != words[fill - 1 - i])
                     match = 1'b0;
               expected_q.push_back(mk_result(STAT_OK, '0, match, 1'b1));
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         fill = 0;
         expected_q.delete();
         outstanding <= 0;
      end else begin
         // responses first: a response never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display({"%0t: unexpected response expected none",
                         " got status=%0d data=%0d pal=%0b last=%0b"},
                        $time, rsp_data.status, rsp_data.data,
                        rsp_data.is_palindrome, rsp_data.last);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.data !== want.data ||
                   rsp_data.is_palindrome !== want.is_palindrome ||
                   rsp_data.last !== want.last) begin
                  errors++;
                  $display({"%0t: mismatch expected status=%0d data=%0d pal=%0b last=%0b",
                            " got status=%0d data=%0d pal=%0b last=%0b"},
                           $time, want.status, want.data, want.is_palindrome, want.last,
                           rsp_data.status, rsp_data.data, rsp_data.is_palindrome,
                           rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready)
            predict_stack_op(req_data);
         outstanding <= expected_q.size();
      end
   end

endmodule

// File: verif/tb_bounded_lifo_stack_with_palindrome.sv
// Testbench top for the bounded LIFO stack: clock, reset, request stimulus and
// response backpressure, verdict. Depends on blstk_pkg, blstk_checker and the RTL.
`timescale 1ns / 100ps

module tb_bounded_lifo_stack_with_palindrome;
   import blstk_pkg::*;

   localparam int RANDOM_END = 115;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;
   bit      calm = 1'b0;
   int      stack_fill = 0;
   int      sent = 0;

   bounded_lifo_stack_with_palindrome uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   blstk_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3, 4: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // sink pacing: runs of ready, short stalls, occasional long stalls
   always @(posedge clock) begin : rsp_pacing
      int r;
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else if (hold != 0) begin
         hold--;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 55) begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(0, 15);
         end else if (r < 90) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(8, 40);
         end
      end
   end

   task automatic send_item(input cmd_type c, input logic signed [WORD_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: c, push_value: v};
      do @(posedge clock); while (!req_ready);
      sent++;
      case (c)
         CMD_PUSH: if (stack_fill < DEPTH) stack_fill++;
         CMD_POP:  if (stack_fill > 0) stack_fill--;
         default: ;
      endcase
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      logic signed [WORD_W-1:0] mirror [DEPTH];
      int r;
      int len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty stack on every command that reads it
      send_item(CMD_POP, pick_value());
      send_item(CMD_DISPLAY, pick_value());
      send_item(CMD_PAL, pick_value());
      // word extremes, single-word and two-word palindrome
      send_item(CMD_PUSH, 32'sh8000_0000);
      send_item(CMD_PAL, 32'sh7FFF_FFFF);
      send_item(CMD_PUSH, 32'sh7FFF_FFFF);
      send_item(CMD_PAL, -32'sd1);
      send_item(CMD_DISPLAY, 32'sd0);
      send_item(CMD_POP, 32'sd0);
      send_item(CMD_POP, 32'sd0);
      send_item(CMD_POP, 32'sd0);
      // odd-length palindrome, then broken by a new top
      send_item(CMD_PUSH, 32'sd5);
      send_item(CMD_PUSH, -32'sd1);
      send_item(CMD_PUSH, 32'sd5);
      send_item(CMD_PAL, 32'sd0);
      send_item(CMD_PUSH, 32'sd0);
      send_item(CMD_PAL, 32'sd0);
      send_item(CMD_DISPLAY, 32'sd0);
      send_item(CMD_PUSH, -32'sd1);
      send_item(CMD_POP, 32'sd0);
      wait_for_drain();

      while (sent < RANDOM_END) begin
         calm = (sent >= 70 && sent < 95);
         r = $urandom_range(0, 99);
         if (r < 30) begin
            // rebuild the whole stack as a mirrored sequence, sometimes corrupted
            while (stack_fill > 0) send_item(CMD_POP, pick_value());
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEPTH)
                                              : $urandom_range(1, 6);
            for (int k = 0; k < (len + 1) / 2; k++) begin
               mirror[k] = $urandom_range(0, 1) ? pick_value()
                                                : $urandom_range(0, 3);
               mirror[len - 1 - k] = mirror[k];
            end
            if ($urandom_range(0, 2) == 0)
               mirror[$urandom_range(0, len - 1)] ^= 32'sd1 << $urandom_range(0, 31);
            for (int k = 0; k < len; k++) send_item(CMD_PUSH, mirror[k]);
            send_item(CMD_PAL, pick_value());
            if ($urandom_range(0, 1) == 0) send_item(CMD_DISPLAY, pick_value());
         end else if (r < 40) begin
            // fill up and push past the top
            while (stack_fill < DEPTH) send_item(CMD_PUSH, pick_value());
            repeat ($urandom_range(1, 2)) send_item(CMD_PUSH, pick_value());
            send_item(CMD_PAL, pick_value());
            send_item(CMD_DISPLAY, pick_value());
         end else if (r < 48) begin
            // drain and pop once more
            while (stack_fill > 0) send_item(CMD_POP, pick_value());
            send_item(CMD_POP, pick_value());
            if ($urandom_range(0, 1) == 0) wait_for_drain();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40)
               send_item(CMD_PUSH, pick_value());
            else if (r < 70)
               send_item(CMD_POP, pick_value());
            else if (r < 85)
               send_item(CMD_DISPLAY, pick_value());
            else
               send_item(CMD_PAL, pick_value());
         end
      end

      wait_for_drain();
      // give stray responses, such as the rest of a full display, time to show
      repeat (4 * DEPTH) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_bounded_lifo_stack_with_palindrome: PASS");
      else
         $display("tb_bounded_lifo_stack_with_palindrome: FAIL");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_bounded_lifo_stack_with_palindrome: FAIL");
      $finish;
   end

endmodule

// File: bounded_lifo_stack_with_palindrome.f
rtl/core/blstk_pkg.sv
rtl/core/blstk_mem.sv
rtl/core/blstk_ctrl.sv
rtl/core/bounded_lifo_stack_with_palindrome.sv
verif/blstk_checker.sv
verif/tb_bounded_lifo_stack_with_palindrome.sv
